@@ design/descriptor_slot_table_defines.svh @@
// Assertion macros shared by the descriptor slot table.
`ifndef DESCRIPTOR_SLOT_TABLE_DEFINES_SVH
`define DESCRIPTOR_SLOT_TABLE_DEFINES_SVH

// Checks cons in the same cycle as ante.
`define DST_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("descriptor_slot_table: assertion failed");

// Checks cons in the cycle after ante.
`define DST_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("descriptor_slot_table: assertion failed");

`endif

@@ design/dst_pkg.sv @@
package dst_pkg;

    localparam int SLOTS_DEF       = 64;
    localparam int HANDLE_BITS_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int FD_W     = 8;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] FN_GET       = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSTALL   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLOSE     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DUP       = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DUP2      = 3'd5;
    localparam logic [FUNC_W-1:0] FN_CLOSE_ALL = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } dst_state_t;

    typedef enum logic [1:0] {
        FSEL_ZERO,
        FSEL_HANDLE,
        FSEL_RDATA
    } dst_fsel_t;

endpackage

@@ design/dst_handle_mem.sv @@
module dst_handle_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/dst_free_find.sv @@
module dst_free_find #(
    parameter int SLOTS = 64,
    parameter int IDX_W = 6
) (
    input  logic [SLOTS-1:0] occ,
    input  logic [IDX_W-1:0] lo,
    output logic             found,
    output logic [IDX_W-1:0] pick
);

    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!occ[i] && (IDX_W'(i) >= lo))
            begin
                found = 1'b1;
                pick  = IDX_W'(i);
            end
        end
    end

endmodule

@@ design/descriptor_slot_table.sv @@
// Channel   Handshake                 Payload
// command   start, busy               func, target_fd, second_fd, file_handle
// result    done (one-cycle strobe)   status, fd_out, file_out, closed_count
//
// A command beat is taken when start is high and busy is low. Most commands pass
// through S_EXEC, which checks the occupied bits and reads the handle memory, and
// S_RESP, which writes back; the result beat is registered out of S_RESP while the
// next command runs. Close all walks the occupied bits one slot a cycle in S_SCAN.
// Reset clears every occupied bit at once; the handle memory needs no clearing.
// The result beat cannot be stalled.
`include "descriptor_slot_table_defines.svh"

module descriptor_slot_table #(
    parameter int SLOTS       = dst_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [dst_pkg::FUNC_W-1:0]     func,
    input  logic [dst_pkg::FD_W-1:0]       target_fd,
    input  logic [dst_pkg::FD_W-1:0]       second_fd,
    input  logic [dst_pkg::HANDLE_W-1:0]   file_handle,
    output logic                           done,
    output logic [dst_pkg::STATUS_W-1:0]   status,
    output logic [dst_pkg::FD_W-1:0]       fd_out,
    output logic [dst_pkg::HANDLE_W-1:0]   file_out,
    output logic [dst_pkg::COUNT_W-1:0]    closed_count
);

    import dst_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    dst_state_t state_reg, state_next;

    logic [FUNC_W-1:0]      func_reg;
    logic [FD_W-1:0]        a_reg;
    logic [FD_W-1:0]        b_reg;
    logic [HANDLE_BITS-1:0] h_reg;

    logic [SLOTS-1:0]       occ_reg, occ_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [STATUS_W-1:0]    dec_status_reg, dec_status_next;
    logic [IDX_W-1:0]       dec_fd_reg, dec_fd_next;
    dst_fsel_t              fsel_reg, fsel_next;
    logic                   wb_en_reg, wb_en_next;
    logic [IDX_W-1:0]       wb_addr_reg, wb_addr_next;

    logic                   done_reg, done_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [FD_W-1:0]        fd_out_reg, fd_out_next;
    logic [HANDLE_W-1:0]    file_out_reg, file_out_next;
    logic [COUNT_W-1:0]     closed_reg, closed_next;

    logic                   accept;
    logic                   a_ok;
    logic                   b_ok;
    logic [IDX_W-1:0]       ai;
    logic [IDX_W-1:0]       bi;
    logic                   occ_a;
    logic                   found;
    logic [IDX_W-1:0]       pick;

    logic                   wen;
    logic [IDX_W-1:0]       waddr;
    logic [HANDLE_BITS-1:0] wdata;
    logic                   ren;
    logic [IDX_W-1:0]       raddr;
    logic [HANDLE_BITS-1:0] rdata;

    assign busy   = (state_reg == S_EXEC) || (state_reg == S_SCAN);
    assign accept = start && !busy;

    assign ai    = a_reg[IDX_W-1:0];
    assign bi    = b_reg[IDX_W-1:0];
    assign a_ok  = a_reg < FD_W'(SLOTS);
    assign b_ok  = b_reg < FD_W'(SLOTS);
    assign occ_a = a_ok && occ_reg[ai];

    dst_free_find #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_free_find (
        .occ   (occ_reg),
        .lo    (bi),
        .found (found),
        .pick  (pick)
    );

    dst_handle_mem #(
        .DEPTH (SLOTS),
        .WIDTH (HANDLE_BITS),
        .AW    (IDX_W)
    ) u_handle_mem (
        .clk   (clk),
        .wen   (wen),
        .waddr (waddr),
        .wdata (wdata),
        .ren   (ren),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            scan_reg  <= '0;
            cnt_reg   <= '0;
            wb_en_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            scan_reg  <= scan_next;
            cnt_reg   <= cnt_next;
            wb_en_reg <= wb_en_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            a_reg    <= target_fd;
            b_reg    <= second_fd;
            h_reg    <= HANDLE_BITS'(file_handle);
        end
        dec_status_reg <= dec_status_next;
        dec_fd_reg     <= dec_fd_next;
        fsel_reg       <= fsel_next;
        wb_addr_reg    <= wb_addr_next;
        status_reg     <= status_next;
        fd_out_reg     <= fd_out_next;
        file_out_reg   <= file_out_next;
        closed_reg     <= closed_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        scan_next       = scan_reg;
        cnt_next        = cnt_reg;
        dec_status_next = dec_status_reg;
        dec_fd_next     = dec_fd_reg;
        fsel_next       = fsel_reg;
        wb_en_next      = wb_en_reg;
        wb_addr_next    = wb_addr_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        fd_out_next     = fd_out_reg;
        file_out_next   = file_out_reg;
        closed_next     = closed_reg;
        wen             = 1'b0;
        waddr           = ai;
        wdata           = h_reg;
        ren             = 1'b0;
        raddr           = ai;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next      = S_RESP;
                dec_status_next = ST_OK;
                dec_fd_next     = '0;
                fsel_next       = FSEL_ZERO;
                wb_en_next      = 1'b0;
                wb_addr_next    = bi;
                cnt_next        = '0;
                case (func_reg)
                    FN_GET:
                    begin
                        if (!a_ok)
                        begin
                            dec_status_next = ST_INVAL;
                        end
                        else if (!occ_a)
                        begin
                            dec_status_next = ST_NOENT;
                        end
                        else
                        begin
                            ren       = 1'b1;
                            fsel_next = FSEL_RDATA;
                        end
                    end

                    FN_INSTALL:
                    begin
                        if (!a_ok)
                        begin
                            dec_status_next = ST_INVAL;
                        end
                        else if (occ_a)
                        begin
                            dec_status_next = ST_INVAL;
                            ren             = 1'b1;
                            fsel_next       = FSEL_RDATA;
                        end
                        else
                        begin
                            wen          = 1'b1;
                            occ_next[ai] = 1'b1;
                            fsel_next    = FSEL_HANDLE;
                        end
                    end

                    FN_ALLOC:
                    begin
                        if (!b_ok)
                        begin
                            dec_status_next = ST_INVAL;
                        end
                        else if (!found)
                        begin
                            dec_status_next = ST_FULL;
                        end
                        else
                        begin
                            wen            = 1'b1;
                            waddr          = pick;
                            occ_next[pick] = 1'b1;
                            dec_fd_next    = pick;
                            fsel_next      = FSEL_HANDLE;
                        end
                    end

                    FN_CLOSE:
                    begin
                        if (!a_ok)
                        begin
                            dec_status_next = ST_INVAL;
                        end
                        else if (!occ_a)
                        begin
                            dec_status_next = ST_NOENT;
                        end
                        else
                        begin
                            occ_next[ai] = 1'b0;
                        end
                    end

                    FN_DUP:
                    begin
                        if (!a_ok)
                        begin
                            dec_status_next = ST_INVAL;
                        end
                        else if (!occ_a)
                        begin
                            dec_status_next = ST_NOENT;
                        end
                        else if (!b_ok)
                        begin
                            dec_status_next = ST_INVAL;
                        end
                        else if (!found)
                        begin
                            dec_status_next = ST_FULL;
                        end
                        else
                        begin
                            ren            = 1'b1;
                            occ_next[pick] = 1'b1;
                            wb_en_next     = 1'b1;
                            wb_addr_next   = pick;
                            dec_fd_next    = pick;
                            fsel_next      = FSEL_RDATA;
                        end
                    end

                    FN_DUP2:
                    begin
                        if (!a_ok || !b_ok)
                        begin
                            dec_status_next = ST_INVAL;
                        end
                        else if (!occ_a)
                        begin
                            dec_status_next = ST_NOENT;
                        end
                        else
                        begin
                            ren       = 1'b1;
                            fsel_next = FSEL_RDATA;
                            if (a_reg != b_reg)
                            begin
                                occ_next[bi] = 1'b1;
                                wb_en_next   = 1'b1;
                            end
                        end
                    end

                    FN_CLOSE_ALL:
                    begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end

                    default:
                    begin
                        dec_status_next = ST_INVAL;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (occ_reg[scan_reg])
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                occ_next[scan_reg] = 1'b0;
                if (scan_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end

            S_RESP:
            begin
                done_next   = 1'b1;
                status_next = dec_status_reg;
                fd_out_next = FD_W'(dec_fd_reg);
                if (9'(cnt_reg) > 9'(COUNT_MAX))
                begin
                    closed_next = COUNT_MAX;
                end
                else
                begin
                    closed_next = COUNT_W'(cnt_reg);
                end
                case (fsel_reg)
                    FSEL_HANDLE: file_out_next = HANDLE_W'(h_reg);
                    FSEL_RDATA:  file_out_next = HANDLE_W'(rdata);
                    default:     file_out_next = '0;
                endcase
                if (wb_en_reg)
                begin
                    wen   = 1'b1;
                    waddr = wb_addr_reg;
                    wdata = rdata;
                end
                wb_en_next = 1'b0;
                state_next = accept ? S_EXEC : S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign fd_out       = fd_out_reg;
    assign file_out     = file_out_reg;
    assign closed_count = closed_reg;

    `DST_ASSERT_NEXT(a_exec_moves_on, clk, rst_n, state_reg == S_EXEC,
        state_reg == S_RESP || state_reg == S_SCAN)
    `DST_ASSERT_NOW(a_done_after_resp, clk, rst_n, done_reg, $past(state_reg == S_RESP))
    `DST_ASSERT_NOW(a_close_all_empties, clk, rst_n,
        state_reg == S_RESP && func_reg == FN_CLOSE_ALL, occ_reg == '0)
    `DST_ASSERT_NOW(a_fail_no_fd, clk, rst_n, done_reg && status_reg != ST_OK,
        fd_out_reg == '0)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import dst_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int IDX_W          = $clog2(SLOTS);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 600;
    localparam int SETTLE_CYCLES  = SLOTS + 16;

    localparam logic [FUNC_W-1:0] FN_UNDEF = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [FD_W-1:0]     target;
        logic [FD_W-1:0]     second;
        logic [HANDLE_W-1:0] handle;
        logic                drain;
        logic                calm;
    } slot_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FD_W-1:0]     fd;
        logic [HANDLE_W-1:0] file;
        logic [COUNT_W-1:0]  count;
    } slot_res_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [FUNC_W-1:0]   func        = '0;
    logic [FD_W-1:0]     target_fd   = '0;
    logic [FD_W-1:0]     second_fd   = '0;
    logic [HANDLE_W-1:0] file_handle = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [FD_W-1:0]     fd_out;
    logic [HANDLE_W-1:0] file_out;
    logic [COUNT_W-1:0]  closed_count;

    slot_cmd_t pending_cmds[$];
    slot_res_t expected_results[$];

    logic                slot_used [SLOTS];
    logic [HANDLE_W-1:0] slot_handle [SLOTS];

    logic cmd_taken = 1'b0;
    int   errors    = 0;
    int   n_cmds    = 0;
    int   n_results = 0;
    int   stall_cycles = 0;
    int   status_seen [4] = '{0, 0, 0, 0};

    descriptor_slot_table #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS_DEF)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .target_fd    (target_fd),
        .second_fd    (second_fd),
        .file_handle  (file_handle),
        .done         (done),
        .status       (status),
        .fd_out       (fd_out),
        .file_out     (file_out),
        .closed_count (closed_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic slot_res_t apply_cmd(input slot_cmd_t c);
        slot_res_t           r;
        logic [HANDLE_W-1:0] h;
        logic [IDX_W-1:0]    ta;
        logic [IDX_W-1:0]    sb;
        int                  pick;
        int                  n;
        int                  i;
        r    = '0;
        h    = c.handle;
        ta   = c.target[IDX_W-1:0];
        sb   = c.second[IDX_W-1:0];
        pick = -1;
        n    = 0;
        case (c.func)
            FN_GET:
            begin
                if (c.target >= SLOTS)
                    r.status = ST_INVAL;
                else if (!slot_used[ta])
                    r.status = ST_NOENT;
                else
                    r.file = slot_handle[ta];
            end
            FN_INSTALL:
            begin
                if (c.target >= SLOTS)
                    r.status = ST_INVAL;
                else if (slot_used[ta])
                begin
                    r.status = ST_INVAL;
                    r.file   = slot_handle[ta];
                end
                else
                begin
                    slot_used[ta]   = 1'b1;
                    slot_handle[ta] = h;
                    r.file          = h;
                end
            end
            FN_ALLOC, FN_DUP:
            begin
                if (c.func == FN_DUP && c.target >= SLOTS)
                    r.status = ST_INVAL;
                else if (c.func == FN_DUP && !slot_used[ta])
                    r.status = ST_NOENT;
                else if (c.second >= SLOTS)
                    r.status = ST_INVAL;
                else
                begin
                    if (c.func == FN_DUP)
                        h = slot_handle[ta];
                    for (i = int'(c.second); i < SLOTS && pick < 0; i++)
                        if (!slot_used[IDX_W'(i)])
                            pick = i;
                    if (pick < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_used[IDX_W'(pick)]   = 1'b1;
                        slot_handle[IDX_W'(pick)] = h;
                        r.fd                      = pick[FD_W-1:0];
                        r.file                    = h;
                    end
                end
            end
            FN_CLOSE:
            begin
                if (c.target >= SLOTS)
                    r.status = ST_INVAL;
                else if (!slot_used[ta])
                    r.status = ST_NOENT;
                else
                begin
                    slot_used[ta]   = 1'b0;
                    slot_handle[ta] = '0;
                end
            end
            FN_DUP2:
            begin
                if (c.target >= SLOTS || c.second >= SLOTS)
                    r.status = ST_INVAL;
                else if (!slot_used[ta])
                    r.status = ST_NOENT;
                else
                begin
                    if (c.target != c.second)
                    begin
                        slot_handle[sb] = slot_handle[ta];
                        slot_used[sb]   = 1'b1;
                    end
                    r.file = slot_handle[sb];
                end
            end
            FN_CLOSE_ALL:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[IDX_W'(i)])
                    begin
                        n++;
                        slot_used[IDX_W'(i)]   = 1'b0;
                        slot_handle[IDX_W'(i)] = '0;
                    end
                end
                r.count = (n > COUNT_MAX) ? COUNT_MAX : n[COUNT_W-1:0];
            end
            default:
                r.status = ST_INVAL;
        endcase
        return r;
    endfunction

    function automatic logic [FD_W-1:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return FD_W'($urandom_range(15));
        else if (r < 85)
            return FD_W'($urandom_range(SLOTS - 1));
        return FD_W'($urandom_range(255));
    endfunction

    function automatic logic [FD_W-1:0] pick_minimum();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return FD_W'($urandom_range(7));
        else if (r < 80)
            return FD_W'($urandom_range(SLOTS - 1, SLOTS - 16));
        return pick_index();
    endfunction

    function automatic slot_cmd_t random_cmd();
        slot_cmd_t c;
        int        r;
        c        = '0;
        c.target = pick_index();
        c.handle = $urandom;
        r        = $urandom_range(99);
        if (r < 14)
            c.func = FN_GET;
        else if (r < 30)
            c.func = FN_INSTALL;
        else if (r < 52)
            c.func = FN_ALLOC;
        else if (r < 64)
            c.func = FN_CLOSE;
        else if (r < 80)
            c.func = FN_DUP;
        else if (r < 93)
            c.func = FN_DUP2;
        else if (r < 95)
            c.func = FN_CLOSE_ALL;
        else if (r < 97)
            c.func = FN_UNDEF;
        else
            c.func = FUNC_W'($urandom_range(7));
        if (c.func == FN_DUP2)
            c.second = pick_index();
        else if (c.func == FN_ALLOC || c.func == FN_DUP)
            c.second = pick_minimum();
        else
            c.second = FD_W'($urandom_range(255));
        return c;
    endfunction

    task automatic add_cmd(input logic [FUNC_W-1:0] f, input int a, input int b,
                           input logic [HANDLE_W-1:0] h);
        slot_cmd_t c;
        c        = '0;
        c.func   = f;
        c.target = FD_W'(a);
        c.second = FD_W'(b);
        c.handle = h;
        pending_cmds.push_back(c);
    endtask

    initial
    begin : main
        slot_cmd_t c;
        int        k;
        for (k = 0; k < SLOTS; k++)
        begin
            slot_used[IDX_W'(k)]   = 1'b0;
            slot_handle[IDX_W'(k)] = '0;
        end

        add_cmd(FN_GET,       0,   0,   32'h0);
        add_cmd(FN_GET,       255, 255, 32'hFFFF_FFFF);
        add_cmd(FN_INSTALL,   0,   0,   32'hFFFF_FFFF);
        add_cmd(FN_INSTALL,   0,   0,   32'h0);
        add_cmd(FN_INSTALL,   63,  0,   32'h0);
        add_cmd(FN_INSTALL,   64,  0,   32'hA5A5_5A5A);
        add_cmd(FN_ALLOC,     0,   0,   32'h1234_5678);
        add_cmd(FN_ALLOC,     0,   64,  32'h5A5A_A5A5);
        add_cmd(FN_ALLOC,     0,   63,  32'h0F0F_F0F0);
        add_cmd(FN_GET,       63,  0,   32'h0);
        add_cmd(FN_CLOSE,     1,   0,   32'h0);
        add_cmd(FN_CLOSE,     1,   0,   32'h0);
        add_cmd(FN_CLOSE,     200, 0,   32'h0);
        add_cmd(FN_DUP,       0,   0,   32'h0);
        add_cmd(FN_DUP,       5,   0,   32'h0);
        add_cmd(FN_DUP,       0,   255, 32'h0);
        add_cmd(FN_DUP,       255, 0,   32'h0);
        add_cmd(FN_DUP2,      0,   10,  32'h0);
        add_cmd(FN_DUP2,      0,   0,   32'h0);
        add_cmd(FN_DUP2,      1,   63,  32'h0);
        add_cmd(FN_DUP2,      7,   8,   32'h0);
        add_cmd(FN_DUP2,      0,   64,  32'h0);
        add_cmd(FN_DUP2,      64,  0,   32'h0);
        add_cmd(FN_UNDEF,     0,   0,   32'hFFFF_FFFF);
        add_cmd(FN_CLOSE_ALL, 0,   0,   32'h0);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            c       = random_cmd();
            c.calm  = (k >= 100 && k < 220);
            c.drain = (k == 300 || k == 450);
            pending_cmds.push_back(c);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d commands and %0d results over all operations and index extremes.",
                 n_cmds, n_results);
        $display("Statuses seen: ok %0d, invalid %0d, no entry %0d, table full %0d; errors %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk)
    begin : driver
        if (rst_n && (!start || cmd_taken))
        begin
            if (cmd_taken)
                void'(pending_cmds.pop_front());
            if (pending_cmds.size() == 0)
                start <= 1'b0;
            else if (pending_cmds[0].drain && expected_results.size() != 0)
                start <= 1'b0;
            else if (!pending_cmds[0].calm && $urandom_range(99) < 14)
                start <= 1'b0;
            else
            begin
                start       <= 1'b1;
                func        <= pending_cmds[0].func;
                target_fd   <= pending_cmds[0].target;
                second_fd   <= pending_cmds[0].second;
                file_handle <= pending_cmds[0].handle;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        slot_res_t got;
        slot_res_t want;
        slot_cmd_t cur;
        if (!rst_n)
            cmd_taken <= 1'b0;
        else
        begin
            cmd_taken <= start && !busy;
            if (done)
            begin
                got = '{status, fd_out, file_out, closed_count};
                n_results++;
                status_seen[status]++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result beat: status %0d fd %0d file %h count %0d",
                                 got.status, got.fd, got.file, got.count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.fd !== want.fd ||
                        got.file !== want.file || got.count !== want.count)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("Mismatch on result %0d: expected status %0d fd %0d file %h count %0d",
                                     n_results, want.status, want.fd, want.file, want.count);
                            $display("    got status %0d fd %0d file %h count %0d",
                                     got.status, got.fd, got.file, got.count);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                cur = '{func, target_fd, second_fd, file_handle, 1'b0, 1'b0};
                expected_results.push_back(apply_cmd(cur));
                n_cmds++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d cycles without a beat.", stall_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule

@@ files.f @@
+incdir+design
design/dst_pkg.sv
design/dst_handle_mem.sv
design/dst_free_find.sv
design/descriptor_slot_table.sv
tb/tb.sv
